// File: rtl/core/pfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// shared types and codes for the pixel format to rgba8 converter
// ----------------------------------------------------------------------------
package pfr_pkg;

   localparam int LANES      = 4;
   localparam int CHAN_W     = 8;
   localparam int HALF_W     = 16;
   localparam int FMT_W      = 3;
   localparam int REQ_DATA_W = 2 * LANES * CHAN_W;
   localparam int RSP_DATA_W = LANES * CHAN_W;

   typedef enum logic [FMT_W-1:0] {
      FMT_RGBA8   = 3'd0,
      FMT_BGRA8   = 3'd1,
      FMT_RGBA16  = 3'd2,
      FMT_RGBA16F = 3'd3,
      FMT_NONE    = 3'd4
   } pfr_format_type;

   typedef struct packed {
      logic [CHAN_W-1:0] ch8;
      logic [HALF_W-1:0] half;
   } pfr_lane_in_type;

   typedef struct packed {
      logic valid;
      logic last;
   } pfr_stage_type;

endpackage

// File: rtl/core/pixel_format_to_rgba8.sv
`timescale 1ns / 1ps
// an accepted req word passes the lane register, then the output register, to rsp_tvalid
// throughput: one pixel per cycle unless the output stalls, four channel lanes run side by side
// the lane register and the output register each hold one word
// reset: synchronous, active high; clears the word valids and sets rgba8
// ----------------------------------------------------------------------------
// pixel_format_to_rgba8
// converts one source pixel per word to packed rgba8 under a chosen format
// ----------------------------------------------------------------------------
module pixel_format_to_rgba8 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfr_pkg::FMT_W-1:0]          csr_data,   // pixel_format
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pfr_pkg::REQ_DATA_W-1:0]     req_tdata,  // byte0 .. byte7
   input  logic                               req_tlast,  // last_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // red, green, blue, alpha
   output logic                               rsp_tlast   // last_out
);
   import pfr_pkg::*;

   pfr_format_type                  fmt_ff;
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_last_ff;
   logic                            out_free;
   logic                            accept;
   pfr_stage_type                   stage;
   pfr_lane_in_type                 lane_in [LANES];
   logic [LANES-1:0][CHAN_W-1:0]    chans;

   assign csr_ready  = 1'b1;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign s1_valid_in = accept ? 1'b1 : (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_RGBA8;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            fmt_ff <= pfr_format_type'(csr_data);
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req_tlast;
      end
   end

   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         // red and blue trade places for bgra8
         localparam int SWAP = (g == 0) ? 2 : ((g == 2) ? 0 : g);

         always_comb begin
            lane_in[g].half = req_tdata[2*g*CHAN_W +: HALF_W];
            lane_in[g].ch8  = (fmt_ff == FMT_BGRA8) ? req_tdata[SWAP*CHAN_W +: CHAN_W]
                                                    : req_tdata[g*CHAN_W +: CHAN_W];
         end

         pfr_lane u_lane (
            .clock   (clock),
            .load    (accept),
            .format  (fmt_ff),
            .lane_in (lane_in[g]),
            .chan_ff (chans[g])
         );
      end
   endgenerate

   assign stage.valid = s1_valid_ff;
   assign stage.last  = s1_last_ff;

   pfr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .chans      (chans),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/core/pfr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_lane
// one channel of the converter: byte pick or half to unorm8, registered
// ----------------------------------------------------------------------------
module pfr_lane (
   input  logic                     clock,
   input  logic                     load,
   input  pfr_pkg::pfr_format_type  format,
   input  pfr_pkg::pfr_lane_in_type lane_in,
   output logic [7:0]               chan_ff
);
   import pfr_pkg::*;

   logic        neg;
   logic [4:0]  expo;
   logic [9:0]  mant;
   logic [10:0] sig;
   logic [4:0]  shift;
   logic [18:0] prod;
   logic [24:0] sum;
   logic [24:0] scaled;
   logic [7:0]  unorm;
   logic [7:0]  chan_in;

   assign neg  = lane_in.half[15];
   assign expo = lane_in.half[14:10];
   assign mant = lane_in.half[9:0];

   always_comb begin
      if (expo == 5'd0) begin
         sig   = {1'b0, mant};
         shift = 5'd24;
      end else begin
         sig   = {1'b1, mant};
         shift = 5'd25 - expo;
      end
   end

   // sig * 255 plus half an lsb of the final scale
   assign prod   = {sig, 8'd0} - {8'd0, sig};
   assign sum    = {6'd0, prod} + (25'd1 << (shift - 5'd1));
   assign scaled = sum >> shift;

   always_comb begin
      priority if (expo == 5'd31) begin
         unorm = (mant != 10'd0 || neg) ? 8'd0 : 8'd255;
      end else if (neg) begin
         unorm = 8'd0;
      end else if (expo >= 5'd15) begin
         unorm = 8'd255;
      end else begin
         unorm = scaled[7:0];
      end
   end

   always_comb begin
      unique case (format)
         FMT_RGBA8, FMT_BGRA8: chan_in = lane_in.ch8;
         FMT_RGBA16:           chan_in = lane_in.half[15:8];
         FMT_RGBA16F:          chan_in = unorm;
         default:              chan_in = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chan_ff <= chan_in;
      end
   end

endmodule

// File: rtl/core/pfr_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_merge
// packs the lane results into one rgba8 word and holds the output register
// ----------------------------------------------------------------------------
module pfr_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  pfr_pkg::pfr_stage_type                      stage,
   input  logic [pfr_pkg::LANES-1:0][pfr_pkg::CHAN_W-1:0] chans,
   output logic                                        out_free,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [pfr_pkg::RSP_DATA_W-1:0]              rsp_tdata,
   output logic                                        rsp_tlast
);
   import pfr_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                  last_ff;
   logic                  take;

   assign out_free = !valid_ff || rsp_tready;
   assign take     = stage.valid && out_free;
   assign valid_in = take ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= chans;
         last_ff <= stage.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/core/pfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_checker
// port level checks of the converter over time
// ----------------------------------------------------------------------------
module pfr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import pfr_pkg::*;

   // no word is shown right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid after reset");

   // a stalled word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // with the consumer ready the pipe never stalls the producer
   a_no_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp ready");

   // an accepted word passes the lane and output registers and shows up while the consumer stays ready
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("rsp word missing after two cycles");

endmodule

bind pixel_format_to_rgba8 pfr_checker u_pfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
